// ===== hw/rtl/crc32tlv_pkg.sv =====
// Package for the CRC-32 tagged line verifier: beat types, parser phases,
// the marker constant and the byte-wise CRC-32 update function.
// Depends on nothing; every module of the block imports it.
package crc32tlv_pkg;

   // Reflected CRC-32 polynomial and the all-ones preset.
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

   // The six bytes " crc32" that must precede the closing '=' of the marker.
   localparam logic [47:0] MARK_BODY = 48'h206372633332;

   // Characters that the tail parser and the marker search look for.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;

   // Phases of the strtoul-style tail parser.
   typedef enum logic [2:0] {
      PH_SPACE  = 3'd0,
      PH_SIGN   = 3'd1,
      PH_ZERO   = 3'd2,
      PH_PREFIX = 3'd3,
      PH_DIGITS = 3'd4,
      PH_DONE   = 3'd5
   } parse_phase_type;

   // One input beat: a byte of the line and its end flag.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_line;
   } req_beat_type;

   // One result beat, given once per line.
   typedef struct packed {
      logic        line_ok;
      logic        marker_found;
      logic [31:0] computed_crc;
      logic [31:0] received_crc;
   } rsp_beat_type;

   // Advances a reflected CRC-32 register by one byte, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] v;
      v = {24'h000000, crc[7:0] ^ b};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
      end
      return (crc >> 8) ^ v;
   endfunction

endpackage

// ===== hw/rtl/crc32_tagged_line_verifier_core.sv =====
// Top level of the CRC-32 tagged line verifier: line state, marker search,
// tail parser and the result register.
// Depends on crc32tlv_pkg.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one byte of
//   a text line per beat, with end_of_line set on the final byte. The block
//   keeps a reflected CRC-32 over the line, finds the last " crc32=" marker,
//   parses the hex tail after it and compares the two values.
//   The response channel (rsp_valid, rsp_stall, rsp_data) carries one beat
//   per line, valid in the cycle after the end_of_line byte was accepted.
//   Throughput is one byte per cycle unless an end_of_line byte is stalled:
//   every byte is fully processed combinationally between the line state
//   registers and the result register, the longest path being the eight-bit
//   CRC update and the hex digit shift.
//   A stalled response holds in the result register. Ordinary bytes are
//   still accepted meanwhile; only an end_of_line byte is stalled until the
//   pending response has been taken.
//   After reset, and after each line's final byte, the line state is back at
//   its start values and the next byte begins a new line.
module crc32_tagged_line_verifier_core #(
   parameter int TAIL_BUFFER_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  crc32tlv_pkg::req_beat_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output crc32tlv_pkg::rsp_beat_type rsp_data
);
   import crc32tlv_pkg::*;

   localparam int TailW = $clog2(TAIL_BUFFER_BYTES);
   localparam logic [TailW-1:0] TailLimit = TailW'(TAIL_BUFFER_BYTES - 1);

   // Line state registers.
   logic [31:0]      running_crc_ff, running_crc_in;
   logic [31:0]      crc_before_space_ff, crc_before_space_in;
   logic [31:0]      prefix_crc_ff, prefix_crc_in;
   logic [47:0]      marker_window_ff, marker_window_in;
   logic             have_marker_ff, have_marker_in;
   logic [TailW-1:0] tail_count_ff, tail_count_in;
   parse_phase_type  parse_phase_ff, parse_phase_in;
   logic [31:0]      parsed_value_ff, parsed_value_in;
   logic             negate_flag_ff, negate_flag_in;
   logic             overflow_flag_ff, overflow_flag_in;
   logic             text_ended_ff, text_ended_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic [7:0]       c;
   logic             c_is_space;
   logic             c_is_hex;
   logic [3:0]       c_digit;
   logic             take_sign_like;
   logic             take_digit_like;
   logic             live;
   logic             found;
   logic [31:0]      recv_value;

   // An end_of_line byte waits while an untaken response holds the register.
   assign req_stall  = rsp_valid_ff && rsp_stall && req_data.end_of_line;
   assign req_accept = req_valid && !req_stall;
   assign c          = req_data.char_byte;
   assign live       = !text_ended_ff && (c != CH_NUL);

   // Character classes for the tail parser.
   always_comb begin
      c_is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      c_is_hex   = 1'b1;
      c_digit    = 4'd0;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         c_digit = 4'(c - CH_ZERO);
      end else if ((c >= CH_LA) && (c <= CH_LF)) begin
         c_digit = 4'(c - CH_LA + 8'd10);
      end else if ((c >= CH_UA) && (c <= CH_UF)) begin
         c_digit = 4'(c - CH_UA + 8'd10);
      end else begin
         c_is_hex = 1'b0;
      end
   end

   // Next line state for one accepted byte, including the tail parser.
   always_comb begin
      running_crc_in      = running_crc_ff;
      crc_before_space_in = crc_before_space_ff;
      prefix_crc_in       = prefix_crc_ff;
      marker_window_in    = marker_window_ff;
      have_marker_in      = have_marker_ff;
      tail_count_in       = tail_count_ff;
      parse_phase_in      = parse_phase_ff;
      parsed_value_in     = parsed_value_ff;
      negate_flag_in      = negate_flag_ff;
      overflow_flag_in    = overflow_flag_ff;
      text_ended_in       = text_ended_ff || (c == CH_NUL);
      take_sign_like      = 1'b0;
      take_digit_like     = 1'b0;

      if (live) begin
         // Parse the byte when it lies within the tail window of a marker.
         if (have_marker_ff && (tail_count_ff < TailLimit)) begin
            tail_count_in = tail_count_ff + 1'b1;
            unique case (parse_phase_ff)
               PH_SPACE: begin
                  if (c_is_space) begin
                     parse_phase_in = PH_SPACE;
                  end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                     negate_flag_in = (c == CH_MINUS);
                     parse_phase_in = PH_SIGN;
                  end else begin
                     take_sign_like = 1'b1;
                  end
               end
               PH_SIGN: begin
                  take_sign_like = 1'b1;
               end
               PH_ZERO: begin
                  if ((c == CH_LX) || (c == CH_UX)) begin
                     parse_phase_in = PH_PREFIX;
                  end else begin
                     take_digit_like = 1'b1;
                  end
               end
               PH_PREFIX, PH_DIGITS: begin
                  take_digit_like = 1'b1;
               end
               default: begin
                  parse_phase_in = parse_phase_ff;
               end
            endcase

            // A leading zero may open a 0x prefix.
            if (take_sign_like && (c == CH_ZERO)) begin
               parse_phase_in = PH_ZERO;
            end else if (take_sign_like || take_digit_like) begin
               if (c_is_hex) begin
                  parse_phase_in = PH_DIGITS;
                  if (!overflow_flag_ff) begin
                     if (parsed_value_ff[31:28] != 4'd0) begin
                        overflow_flag_in = 1'b1;
                     end else begin
                        parsed_value_in = {parsed_value_ff[27:0], c_digit};
                     end
                  end
               end else begin
                  parse_phase_in = PH_DONE;
               end
            end
         end

         // A new marker snapshots the prefix CRC and restarts the tail.
         if ((c == CH_EQUAL) && (marker_window_ff == MARK_BODY)) begin
            have_marker_in   = 1'b1;
            prefix_crc_in    = ~crc_before_space_ff;
            tail_count_in    = '0;
            parse_phase_in   = PH_SPACE;
            parsed_value_in  = 32'd0;
            negate_flag_in   = 1'b0;
            overflow_flag_in = 1'b0;
         end

         if (c == CH_SPACE) begin
            crc_before_space_in = running_crc_ff;
         end
         running_crc_in   = crc_byte(running_crc_ff, c);
         marker_window_in = {marker_window_ff[39:0], c};
      end
   end

   // Result fields from the state after the final byte.
   always_comb begin
      found = have_marker_in && (tail_count_in != '0);
      if (overflow_flag_in) begin
         recv_value = CRC_ALL_ONES;
      end else if (negate_flag_in) begin
         recv_value = 32'd0 - parsed_value_in;
      end else begin
         recv_value = parsed_value_in;
      end
      rsp_data_in.marker_found = found;
      rsp_data_in.computed_crc = found ? prefix_crc_in : 32'd0;
      rsp_data_in.received_crc = found ? recv_value : 32'd0;
      rsp_data_in.line_ok      = found && (prefix_crc_in == recv_value);
      rsp_valid_in = (req_accept && req_data.end_of_line) || (rsp_valid_ff && rsp_stall);
   end

   // Line state registers; the final byte of a line returns them to start.
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_data.end_of_line)) begin
         running_crc_ff      <= CRC_ALL_ONES;
         crc_before_space_ff <= CRC_ALL_ONES;
         prefix_crc_ff       <= 32'd0;
         marker_window_ff    <= 48'd0;
         have_marker_ff      <= 1'b0;
         tail_count_ff       <= '0;
         parse_phase_ff      <= PH_SPACE;
         parsed_value_ff     <= 32'd0;
         negate_flag_ff      <= 1'b0;
         overflow_flag_ff    <= 1'b0;
         text_ended_ff       <= 1'b0;
      end else if (req_accept) begin
         running_crc_ff      <= running_crc_in;
         crc_before_space_ff <= crc_before_space_in;
         prefix_crc_ff       <= prefix_crc_in;
         marker_window_ff    <= marker_window_in;
         have_marker_ff      <= have_marker_in;
         tail_count_ff       <= tail_count_in;
         parse_phase_ff      <= parse_phase_in;
         parsed_value_ff     <= parsed_value_in;
         negate_flag_ff      <= negate_flag_in;
         overflow_flag_ff    <= overflow_flag_in;
         text_ended_ff       <= text_ended_in;
      end
   end

   // Result register: loads on a line's final byte, holds while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.end_of_line) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/crc32tlv_checker.sv =====
// Port-level checker for the CRC-32 tagged line verifier, and its bind.
// Depends on crc32tlv_pkg and on crc32_tagged_line_verifier_core.
module crc32tlv_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input crc32tlv_pkg::req_beat_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input crc32tlv_pkg::rsp_beat_type rsp_data
);
   import crc32tlv_pkg::*;

   // A stalled response beat stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // A final byte that is taken yields a response in the next cycle.
   a_eol_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.end_of_line |=> rsp_valid)
      else $error("no response after end of line");

   // The verdict agrees with the reported CRC values.
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.line_ok ==
         (rsp_data.marker_found && (rsp_data.computed_crc == rsp_data.received_crc))))
      else $error("line verdict disagrees with CRC values");

   // Without a marker both CRC fields read as zero.
   a_no_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.marker_found |->
         (rsp_data.computed_crc == 32'd0) && (rsp_data.received_crc == 32'd0))
      else $error("CRC fields nonzero without a marker");

endmodule

bind crc32_tagged_line_verifier_core crc32tlv_checker u_crc32tlv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
